// ----- sv/lpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Longest palindrome finder package
// Shared constants and the command and status types between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int unsigned MaxCharsDefault = 1024;
  localparam int unsigned SymbolW         = 8;
  localparam int unsigned StartW          = 10;
  localparam int unsigned LengthW         = 11;

  typedef struct packed {
    logic load;
    logic init;
    logic cmp;
    logic upd;
    logic clear;
  } lpf_cmd_t;

  typedef struct packed {
    logic grow_done;
    logic last_grow;
  } lpf_status_t;

endpackage

// ----- sv/lpf_sym_if.sv -----
// ----------------------------------------------------------------------------
// Symbol channel
// Carries one character byte per beat, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface lpf_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ----- sv/lpf_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Carries the start and length of the longest palindrome, one beat a string.
// ----------------------------------------------------------------------------
interface lpf_res_if;
  logic        valid;
  logic        ready;
  logic [9:0]  start_index;
  logic [10:0] length;
  logic        overflow;

  modport source (output valid, output start_index, output length, output overflow,
                  input ready);
  modport sink   (input valid, input start_index, input length, input overflow,
                  output ready);
endinterface

// ----- sv/longest_palindrome_finder.sv -----
// One byte is taken per cycle while loading. After the final byte the search
// runs one set-up step, then for each of the 2n expansions compares pairs
// until a mismatch or an edge and updates the best-so-far registers, then
// presents the result beat.
// One string is handled at a time; the result beat is held until taken.
// Reset empties the buffer count and clears the flags; buffer contents stay.
// ----------------------------------------------------------------------------
// Longest palindrome finder
// Stores a string and reports the start and length of its longest palindrome
// by expanding around every centre.
// ----------------------------------------------------------------------------
module longest_palindrome_finder #(
  parameter int unsigned MAX_CHARS = lpf_pkg::MaxCharsDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  lpf_sym_if.sink    sym_i,
  lpf_res_if.source  res_o
);
  import lpf_pkg::*;

  lpf_cmd_t    cmd;
  lpf_status_t status;

  lpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_valid_i (sym_i.valid),
    .sym_last_i  (sym_i.last),
    .sym_ready_o (sym_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lpf_datapath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .symbol_i      (sym_i.symbol),
    .status_o      (status),
    .start_index_o (res_o.start_index),
    .length_o      (res_o.length),
    .overflow_o    (res_o.overflow)
  );

endmodule

// ----- sv/lpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Longest palindrome finder controller
// Sequences loading, the expansion around each centre and the result beat.
// ----------------------------------------------------------------------------
module lpf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sym_valid_i,
  input  logic                sym_last_i,
  output logic                sym_ready_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  input  lpf_pkg::lpf_status_t status_i,
  output lpf_pkg::lpf_cmd_t    cmd_o
);
  import lpf_pkg::*;

  localparam logic [2:0] SLoad   = 3'd0;
  localparam logic [2:0] SInit   = 3'd1;
  localparam logic [2:0] SCmp    = 3'd2;
  localparam logic [2:0] SUpd    = 3'd3;
  localparam logic [2:0] SResult = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    sym_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      SLoad: begin
        sym_ready_o = 1'b1;
        if (sym_valid_i) begin
          cmd_o.load = 1'b1;
          if (sym_last_i) begin
            state_d = SInit;
          end
        end
      end
      SInit: begin
        cmd_o.init = 1'b1;
        state_d    = SCmp;
      end
      SCmp: begin
        cmd_o.cmp = 1'b1;
        if (status_i.grow_done) begin
          state_d = SUpd;
        end
      end
      SUpd: begin
        cmd_o.upd = 1'b1;
        state_d   = status_i.last_grow ? SResult : SCmp;
      end
      SResult: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d     = SLoad;
        end
      end
      default: begin
        state_d = SLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/lpf_datapath.sv -----
// ----------------------------------------------------------------------------
// Longest palindrome finder datapath
// Character buffer with two read ports, expansion pointers, match counter
// and the best-so-far registers.
// ----------------------------------------------------------------------------
module lpf_datapath #(
  parameter int unsigned MAX_CHARS = lpf_pkg::MaxCharsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpf_pkg::lpf_cmd_t    cmd_i,
  input  logic [7:0]           symbol_i,
  output lpf_pkg::lpf_status_t status_o,
  output logic [9:0]           start_index_o,
  output logic [10:0]          length_o,
  output logic                 overflow_o
);
  import lpf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CHARS);
  localparam int unsigned CW = $clog2(MAX_CHARS + 1);

  logic [SymbolW-1:0] mem [MAX_CHARS];

  logic [CW-1:0]      count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [CW-1:0]      c_q, c_d;
  logic               even_q, even_d;
  logic [CW-1:0]      lo_q, lo_d;
  logic [CW-1:0]      hi_q, hi_d;
  logic [CW-1:0]      steps_q, steps_d;
  logic [AW-1:0]      best_start_q, best_start_d;
  logic [CW-1:0]      best_len_q, best_len_d;
  logic [SymbolW-1:0] rd_lo_q, rd_hi_q;

  logic          full;
  logic          pair_ok;
  logic          lo_zero;
  logic [CW-1:0] c_next;
  logic [CW:0]   len_cand;
  logic [CW-1:0] start_cand;
  logic          better;

  assign full       = (count_q == CW'(MAX_CHARS));
  assign pair_ok    = (hi_q < count_q) && (rd_lo_q == rd_hi_q);
  assign lo_zero    = (lo_q == '0);
  assign c_next     = c_q + CW'(1);
  assign len_cand   = {steps_q, 1'b0} - (CW + 1)'(!even_q);
  assign start_cand = c_next - steps_q;
  assign better     = (len_cand > {1'b0, best_len_q});

  assign status_o.grow_done = !(pair_ok && !lo_zero);
  assign status_o.last_grow = even_q && (c_next == count_q);

  always_comb begin
    count_d      = count_q;
    ovf_d        = ovf_q;
    c_d          = c_q;
    even_d       = even_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    steps_d      = steps_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.init) begin
      c_d          = '0;
      even_d       = 1'b0;
      lo_d         = '0;
      hi_d         = '0;
      steps_d      = '0;
      best_start_d = '0;
      best_len_d   = '0;
    end
    if (cmd_i.cmp && pair_ok) begin
      steps_d = steps_q + CW'(1);
      if (!lo_zero) begin
        lo_d = lo_q - CW'(1);
        hi_d = hi_q + CW'(1);
      end
    end
    if (cmd_i.upd) begin
      if (better) begin
        best_len_d   = CW'(len_cand);
        best_start_d = AW'(start_cand);
      end
      steps_d = '0;
      if (even_q) begin
        even_d = 1'b0;
        c_d    = c_next;
        lo_d   = c_next;
        hi_d   = c_next;
      end else begin
        even_d = 1'b1;
        lo_d   = c_q;
        hi_d   = c_next;
      end
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ovf_q        <= 1'b0;
      c_q          <= '0;
      even_q       <= 1'b0;
      lo_q         <= '0;
      hi_q         <= '0;
      steps_q      <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
    end else begin
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      c_q          <= c_d;
      even_q       <= even_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      steps_q      <= steps_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
    end
  end

  // The read addresses follow the next pointer values, so the registered data
  // lines up with the registered pointers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[count_q[AW-1:0]] <= symbol_i;
    end
    rd_lo_q <= mem[lo_d[AW-1:0]];
    rd_hi_q <= mem[hi_d[AW-1:0]];
  end

  assign start_index_o = StartW'(best_start_q);
  assign length_o      = LengthW'(best_len_q);
  assign overflow_o    = ovf_q;

endmodule

// ----- tb/sv/longest_palindrome_finder_tb.sv -----
// ----------------------------------------------------------------------------
// Longest palindrome finder testbench
// Sends strings of bytes through the symbol channel and checks each result
// beat against a local expand-around-centre search of the same string. Short
// directed strings come first, then random strings under three idling
// patterns, then one string that overruns the buffer and more random strings.
// ----------------------------------------------------------------------------
typedef logic [7:0] text_t[$];

typedef struct packed {
  logic [lpf_pkg::StartW-1:0]  start_index;
  logic [lpf_pkg::LengthW-1:0] length;
  logic                        overflow;
} answer_t;

class palindrome_ledger;
  logic [7:0]  chars [lpf_pkg::MaxCharsDefault];
  int unsigned stored;
  bit          truncated;
  answer_t     expected_answers[$];
  int unsigned failures;

  function new();
    stored    = 0;
    truncated = 1'b0;
    failures  = 0;
  endfunction

  function int unsigned mirror_steps(int unsigned lo, int unsigned hi, int unsigned n);
    int unsigned steps;
    steps = 0;
    while (1) begin
      if (hi >= n) break;
      if (chars[lo] != chars[hi]) break;
      steps++;
      if (lo == 0) break;
      lo--;
      hi++;
    end
    return steps;
  endfunction

  function answer_t find_longest();
    int unsigned odd_r, odd_len, even_r, even_len, best_s, best_l;
    answer_t     answer;
    best_s = 0;
    best_l = 0;
    for (int unsigned c = 0; c < stored; c++) begin
      odd_r    = mirror_steps(c, c, stored) - 1;
      odd_len  = 2 * odd_r + 1;
      even_r   = mirror_steps(c, c + 1, stored);
      even_len = 2 * even_r;
      if (odd_len > even_len) begin
        if (odd_len > best_l) begin
          best_l = odd_len;
          best_s = c - odd_r;
        end
      end else begin
        if (even_len > best_l) begin
          best_l = even_len;
          best_s = c + 1 - even_r;
        end
      end
    end
    answer.start_index = best_s[lpf_pkg::StartW-1:0];
    answer.length      = best_l[lpf_pkg::LengthW-1:0];
    answer.overflow    = truncated;
    return answer;
  endfunction

  function void note_symbol(logic [7:0] symbol, logic last);
    if (stored < lpf_pkg::MaxCharsDefault) begin
      chars[stored] = symbol;
      stored++;
    end else begin
      truncated = 1'b1;
    end
    if (last) begin
      expected_answers.push_back(find_longest());
      stored    = 0;
      truncated = 1'b0;
    end
  endfunction

  function void check_answer(answer_t actual);
    answer_t want;
    if (expected_answers.size() == 0) begin
      $display("%0t: result beat with no string outstanding: start %0d length %0d overflow %0d",
               $time, actual.start_index, actual.length, actual.overflow);
      failures++;
      return;
    end
    want = expected_answers.pop_front();
    if (actual.start_index !== want.start_index) begin
      $display("%0t: start_index mismatch: expected %0d, actual %0d",
               $time, want.start_index, actual.start_index);
      failures++;
    end
    if (actual.length !== want.length) begin
      $display("%0t: length mismatch: expected %0d, actual %0d",
               $time, want.length, actual.length);
      failures++;
    end
    if (actual.overflow !== want.overflow) begin
      $display("%0t: overflow mismatch: expected %0d, actual %0d",
               $time, want.overflow, actual.overflow);
      failures++;
    end
  endfunction
endclass

module longest_palindrome_finder_tb;

  localparam int unsigned BufferDepth = lpf_pkg::MaxCharsDefault;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  palindrome_ledger ledger = new();

  lpf_sym_if sym ();
  lpf_res_if res ();

  longest_palindrome_finder #(
    .MAX_CHARS(BufferDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sym_i (sym.sink),
    .res_o (res.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && sym.valid && sym.ready) begin
      ledger.note_symbol(sym.symbol, sym.last);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      ledger.check_answer('{res.start_index, res.length, res.overflow});
    end
  end

  task automatic send_string(input text_t text);
    for (int i = 0; i < text.size(); i++) begin
      while ($urandom_range(99) < send_idle) begin
        sym.valid <= 1'b0;
        @(posedge clk_i);
      end
      sym.valid  <= 1'b1;
      sym.symbol <= text[i];
      sym.last   <= (i == text.size() - 1);
      @(posedge clk_i);
      while (!sym.ready) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_answers();
    sym.valid <= 1'b0;
    @(posedge clk_i);
    while (ledger.expected_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic make_text(output text_t text);
    int unsigned mode, len, base, spread, half, pre, post;
    logic [7:0]  mid;
    text_t       wing;
    text = {};
    wing = {};
    mode   = $urandom_range(99);
    base   = $urandom_range(255);
    spread = $urandom_range(1, 3);
    len    = ($urandom_range(19) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
    if (mode < 20) begin
      repeat (len) text.push_back($urandom_range(255));
    end else if (mode < 50) begin
      repeat (len) text.push_back(8'(base + $urandom_range(spread - 1)));
    end else begin
      pre  = $urandom_range(5);
      post = $urandom_range(5);
      half = $urandom_range(7);
      mid  = 8'(base + $urandom_range(spread));
      repeat (pre) text.push_back(8'(base + $urandom_range(spread)));
      repeat (half) wing.push_back(8'(base + $urandom_range(spread)));
      foreach (wing[i]) text.push_back(wing[i]);
      if (half == 0 || $urandom_range(1)) text.push_back(mid);
      for (int i = half - 1; i >= 0; i--) text.push_back(wing[i]);
      repeat (post) text.push_back(8'(base + $urandom_range(spread)));
    end
  endtask

  task automatic run_random_strings(input int unsigned item_target);
    int unsigned sent;
    text_t       text;
    sent = 0;
    while (sent < item_target) begin
      make_text(text);
      send_string(text);
      sent += text.size();
    end
  endtask

  initial begin
    text_t text;
    sym.valid  <= 1'b0;
    sym.symbol <= 8'h00;
    sym.last   <= 1'b0;
    rst_ni     <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 19;
    recv_idle = 53;
    text = '{8'h00};                          send_string(text);
    text = '{8'hFF};                          send_string(text);
    text = '{8'h41, 8'h41};                   send_string(text);
    text = '{8'h41, 8'h42, 8'h41};            send_string(text);
    text = '{8'h01, 8'h02, 8'h03};            send_string(text);
    text = '{8'h10, 8'h20, 8'h20, 8'h10};     send_string(text);
    text = '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55};
    send_string(text);
    text = '{8'h7E, 8'h80, 8'h81, 8'h80};     send_string(text);
    wait_for_answers();

    run_random_strings(110);
    wait_for_answers();

    send_idle = 53;
    recv_idle = 19;
    run_random_strings(110);
    wait_for_answers();

    send_idle = 0;
    recv_idle = 0;
    run_random_strings(110);

    // A uniform run that fills the buffer, then bytes that must be dropped.
    text = {};
    repeat (BufferDepth) text.push_back(8'h61);
    text.push_back(8'h62);
    text.push_back(8'h63);
    text.push_back(8'h64);
    send_string(text);
    run_random_strings(20);

    wait_for_answers();
    repeat (50) @(posedge clk_i);
    if (ledger.failures == 0 && ledger.expected_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd4 * 64'd3_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
sv/lpf_pkg.sv
sv/lpf_sym_if.sv
sv/lpf_res_if.sv
sv/lpf_ctrl.sv
sv/lpf_datapath.sv
sv/longest_palindrome_finder.sv
tb/sv/longest_palindrome_finder_tb.sv
